FILE: hw/rtl/scp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants for the serial command line parser: character
// codes, argument sizing, parse modes, sequencer phases and the line record.
// ----------------------------------------------------------------------------
package scp_pkg;

   localparam int ARG_BYTES = 16;
   localparam int ARG_CAP   = ARG_BYTES - 1;
   localparam int CNT_W     = $clog2(ARG_BYTES);
   localparam int IDX_W     = (ARG_CAP > 1) ? $clog2(ARG_CAP) : 1;
   localparam int Q_DEPTH   = 2;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_HI = 8'h7E;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_FIRST  = 2'd1;
   localparam logic [1:0] KIND_SECOND = 2'd2;

   typedef enum logic [1:0] {
      MODE_COMMAND = 2'd0,
      MODE_IGNORE  = 2'd1,
      MODE_FIRST   = 2'd2,
      MODE_SECOND  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_FIRST  = 2'd1,
      PHASE_SECOND = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0]                    command;
      logic [CNT_W-1:0]              first_count;
      logic [CNT_W-1:0]              second_count;
      logic [ARG_CAP-1:0][7:0]       first_chars;
      logic [ARG_CAP-1:0][7:0]       second_chars;
   } line_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   function automatic logic [3:0] len4(input logic [CNT_W-1:0] cnt);
      return 4'(cnt);
   endfunction

endpackage

FILE: hw/rtl/scp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_front
// Accepts received bytes, tracks the parse mode, holds the command and both
// argument buffers, and posts a complete line record on every line feed.
// ----------------------------------------------------------------------------
module scp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  logic [7:0]                   req_rx_byte,
   input  scp_pkg::queue_status_type    q_status,
   output logic                         line_push,
   output scp_pkg::line_type            line_out
);
   import scp_pkg::*;

   mode_type                mode_ff, mode_in;
   logic [7:0]              cmd_ff, cmd_in;
   logic [CNT_W-1:0]        fcnt_ff, fcnt_in;
   logic [CNT_W-1:0]        scnt_ff, scnt_in;
   logic [ARG_CAP-1:0][7:0] fchars_ff, fchars_in;
   logic [ARG_CAP-1:0][7:0] schars_ff, schars_in;
   logic                    accept;
   logic                    printable;

   assign accept    = req_push && !q_status.full;
   assign printable = (req_rx_byte >= PRINT_LO) && (req_rx_byte <= PRINT_HI);

   always_comb begin
      mode_in   = mode_ff;
      cmd_in    = cmd_ff;
      fcnt_in   = fcnt_ff;
      scnt_in   = scnt_ff;
      fchars_in = fchars_ff;
      schars_in = schars_ff;
      line_push = 1'b0;
      if (accept) begin
         priority if (req_rx_byte == CH_LF) begin
            mode_in   = MODE_COMMAND;
            line_push = 1'b1;
         end else if (!printable) begin
            mode_in = MODE_IGNORE;
         end else begin
            unique case (mode_ff)
               MODE_COMMAND: begin
                  if (req_rx_byte == CH_COMMA) begin
                     mode_in = MODE_FIRST;
                  end else begin
                     cmd_in  = req_rx_byte;
                     fcnt_in = '0;
                     scnt_in = '0;
                  end
               end
               MODE_FIRST: begin
                  if (req_rx_byte == CH_COMMA) begin
                     mode_in = MODE_SECOND;
                  end else if (fcnt_ff < CNT_W'(ARG_CAP)) begin
                     fchars_in[fcnt_ff[IDX_W-1:0]] = req_rx_byte;
                     fcnt_in = fcnt_ff + CNT_W'(1);
                  end
               end
               MODE_SECOND: begin
                  if (req_rx_byte == CH_COMMA) begin
                     mode_in = MODE_IGNORE;
                  end else if (scnt_ff < CNT_W'(ARG_CAP)) begin
                     schars_in[scnt_ff[IDX_W-1:0]] = req_rx_byte;
                     scnt_in = scnt_ff + CNT_W'(1);
                  end
               end
               MODE_IGNORE: begin
                  mode_in = MODE_IGNORE;
               end
               default: begin
                  mode_in = MODE_IGNORE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_COMMAND;
         cmd_ff  <= '0;
         fcnt_ff <= '0;
         scnt_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         cmd_ff  <= cmd_in;
         fcnt_ff <= fcnt_in;
         scnt_ff <= scnt_in;
      end
   end

   always_ff @(posedge clock) begin
      fchars_ff <= fchars_in;
      schars_ff <= schars_in;
   end

   always_comb begin
      line_out.command      = cmd_ff;
      line_out.first_count  = fcnt_ff;
      line_out.second_count = scnt_ff;
      line_out.first_chars  = fchars_ff;
      line_out.second_chars = schars_ff;
   end

endmodule

FILE: hw/rtl/scp_line_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_line_queue
// Short queue of complete line records between the parser front and the
// result sequencer.
// ----------------------------------------------------------------------------
module scp_line_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  scp_pkg::line_type            push_line,
   input  logic                         pop,
   output scp_pkg::line_type            head_line,
   output scp_pkg::queue_status_type    status
);
   import scp_pkg::*;

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int FILL_W = $clog2(Q_DEPTH + 1);

   line_type            entry_ff [Q_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                do_push;
   logic                do_pop;

   assign status.full      = (fill_ff == FILL_W'(Q_DEPTH));
   assign status.not_empty = (fill_ff != '0);
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign head_line        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_line;
      end
   end

endmodule

FILE: hw/rtl/scp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_back
// Walks the line record at the queue head and emits the header and each
// argument character through a one-entry output register.
// ----------------------------------------------------------------------------
module scp_back (
   input  logic                         clock,
   input  logic                         reset,
   input  scp_pkg::line_type            head_line,
   input  scp_pkg::queue_status_type    q_status,
   output logic                         line_pop,
   input  logic                         rsp_pop,
   output logic                         rsp_empty,
   output logic [1:0]                   rsp_item_kind,
   output logic [7:0]                   rsp_command_code,
   output logic [7:0]                   rsp_char_value,
   output logic [3:0]                   rsp_first_length,
   output logic [3:0]                   rsp_second_length,
   output logic                         rsp_last_of_line
);
   import scp_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic [1:0]          kind_ff, kind_in;
   logic [7:0]          cmd_ff, cmd_in;
   logic [7:0]          char_ff, char_in;
   logic [3:0]          flen_ff, flen_in;
   logic [3:0]          slen_ff, slen_in;
   logic                last_ff, last_in;
   logic                load;
   logic [CNT_W-1:0]    next_pos;
   logic                f_zero;
   logic                s_zero;

   assign load     = q_status.not_empty && (!valid_ff || rsp_pop);
   assign next_pos = CNT_W'(idx_ff) + CNT_W'(1);
   assign f_zero   = (head_line.first_count == '0);
   assign s_zero   = (head_line.second_count == '0);

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_pop;
      kind_in  = kind_ff;
      cmd_in   = cmd_ff;
      char_in  = char_ff;
      flen_in  = flen_ff;
      slen_in  = slen_ff;
      last_in  = last_ff;
      line_pop = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         cmd_in   = head_line.command;
         flen_in  = len4(head_line.first_count);
         slen_in  = len4(head_line.second_count);
         unique case (phase_ff)
            PHASE_HEADER: begin
               kind_in = KIND_HEADER;
               char_in = '0;
               last_in = f_zero && s_zero;
               idx_in  = '0;
               priority if (!f_zero) begin
                  phase_in = PHASE_FIRST;
               end else if (!s_zero) begin
                  phase_in = PHASE_SECOND;
               end else begin
                  line_pop = 1'b1;
               end
            end
            PHASE_FIRST: begin
               kind_in = KIND_FIRST;
               char_in = head_line.first_chars[idx_ff];
               last_in = (next_pos == head_line.first_count) && s_zero;
               if (next_pos == head_line.first_count) begin
                  idx_in = '0;
                  if (s_zero) begin
                     phase_in = PHASE_HEADER;
                     line_pop = 1'b1;
                  end else begin
                     phase_in = PHASE_SECOND;
                  end
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            PHASE_SECOND: begin
               kind_in = KIND_SECOND;
               char_in = head_line.second_chars[idx_ff];
               last_in = (next_pos == head_line.second_count);
               if (next_pos == head_line.second_count) begin
                  idx_in   = '0;
                  phase_in = PHASE_HEADER;
                  line_pop = 1'b1;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            default: begin
               phase_in = PHASE_HEADER;
               idx_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HEADER;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      cmd_ff  <= cmd_in;
      char_ff <= char_in;
      flen_ff <= flen_in;
      slen_ff <= slen_in;
      last_ff <= last_in;
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_item_kind     = kind_ff;
   assign rsp_command_code  = cmd_ff;
   assign rsp_char_value    = char_ff;
   assign rsp_first_length  = flen_ff;
   assign rsp_second_length = slen_ff;
   assign rsp_last_of_line  = last_ff;

endmodule

FILE: hw/rtl/serial_command_line_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_line_parser_top
// Parses command lines from a received byte stream and emits a header plus
// the stored argument characters of each line.
// ----------------------------------------------------------------------------
// A byte is taken whenever the line queue is not full; full rises only while
// two complete lines wait in the line queue.
// A line feed posts its record into the line queue; its header comes out
// first, then its characters (1 + first length + second length results).
// With rsp_pop held, the output register gives one result per cycle.
// Synchronous reset returns to command mode with no command and empty
// arguments; argument buffers stay undefined until written.
module serial_command_line_parser_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  logic [7:0]   req_rx_byte,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [1:0]   rsp_item_kind,
   output logic [7:0]   rsp_command_code,
   output logic [7:0]   rsp_char_value,
   output logic [3:0]   rsp_first_length,
   output logic [3:0]   rsp_second_length,
   output logic         rsp_last_of_line
);
   import scp_pkg::*;

   queue_status_type q_status;
   line_type         front_line;
   line_type         head_line;
   logic             line_push;
   logic             line_pop;

   assign req_full = q_status.full;

   scp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .line_push   (line_push),
      .line_out    (front_line)
   );

   scp_line_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (line_push),
      .push_line (front_line),
      .pop       (line_pop),
      .head_line (head_line),
      .status    (q_status)
   );

   scp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_line         (head_line),
      .q_status          (q_status),
      .line_pop          (line_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_command_code  (rsp_command_code),
      .rsp_char_value    (rsp_char_value),
      .rsp_first_length  (rsp_first_length),
      .rsp_second_length (rsp_second_length),
      .rsp_last_of_line  (rsp_last_of_line)
   );

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result waiting right after reset");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      line_push |-> !q_status.full)
      else $error("line record posted into a full queue");

   a_pop_has_line: assert property (@(posedge clock) disable iff (reset)
      line_pop |-> q_status.not_empty)
      else $error("line record retired from an empty queue");

   a_header_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item_kind == KIND_HEADER) |->
      (rsp_last_of_line == (rsp_first_length == 4'd0 && rsp_second_length == 4'd0)))
      else $error("header end flag disagrees with argument lengths");

   a_line_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_last_of_line) |=>
      (!rsp_empty && rsp_item_kind != KIND_HEADER))
      else $error("line broken off before its final transfer");

endmodule

FILE: test/serial_command_line_parser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_line_parser_top_test
// Feeds received bytes into the command line parser and checks every emitted
// header and argument character against a byte-level line parser kept here.
// A directed table hits empty lines, field extremes, third commas, carriage
// returns and non-printable bytes. Random lines follow, mostly well formed,
// with random stalls on both sides.
// ----------------------------------------------------------------------------
module serial_command_line_parser_top_test;
   import scp_pkg::*;

   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 5;
   localparam int ITEM_TARGET  = 270;
   localparam int CALM_AFTER   = 210;
   localparam int IDLE_LIMIT   = 1000;
   localparam int TAIL_CYCLES  = 20;
   localparam int ROW_COUNT    = 23;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] command;
      logic [7:0] char_value;
      logic [3:0] first_len;
      logic [3:0] second_len;
      logic       last;
   } parsed_item_type;

   typedef struct {
      logic [7:0]      rx;
      bit              fixed;
      parsed_item_type item;
   } byte_row_type;

   localparam parsed_item_type NO_ITEM   = '0;
   localparam parsed_item_type BARE_NONE = '{KIND_HEADER, 8'h00, 8'h00, 4'd0, 4'd0, 1'b1};
   localparam parsed_item_type BARE_B    = '{KIND_HEADER, 8'h42, 8'h00, 4'd0, 4'd0, 1'b1};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_pop = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic [1:0] rsp_item_kind;
   logic [7:0] rsp_command_code;
   logic [7:0] rsp_char_value;
   logic [3:0] rsp_first_length;
   logic [3:0] rsp_second_length;
   logic       rsp_last_of_line;

   // line parser state
   mode_type   line_mode = MODE_COMMAND;
   logic [7:0] cmd_held = 8'h00;
   logic [7:0] first_chars [ARG_CAP];
   logic [7:0] second_chars [ARG_CAP];
   int         first_n = 0;
   int         second_n = 0;

   parsed_item_type line_items [$];
   parsed_item_type items_due [$];
   int              mismatch_count = 0;
   int              bytes_sent = 0;
   int              idle_cycles = 0;
   bit              calm = 1'b0;

   byte_row_type directed_rows [ROW_COUNT] = '{
      '{CH_LF,    1'b1, BARE_NONE},
      '{8'h41,    1'b0, NO_ITEM},
      '{CH_COMMA, 1'b0, NO_ITEM},
      '{PRINT_LO, 1'b0, NO_ITEM},
      '{CH_COMMA, 1'b0, NO_ITEM},
      '{PRINT_HI, 1'b0, NO_ITEM},
      '{CH_COMMA, 1'b0, NO_ITEM},
      '{8'h71,    1'b0, NO_ITEM},
      '{CH_LF,    1'b0, NO_ITEM},
      '{CH_LF,    1'b0, NO_ITEM},
      '{8'hFF,    1'b0, NO_ITEM},
      '{CH_CR,    1'b0, NO_ITEM},
      '{CH_LF,    1'b0, NO_ITEM},
      '{8'h42,    1'b0, NO_ITEM},
      '{CH_CR,    1'b0, NO_ITEM},
      '{CH_LF,    1'b1, BARE_B},
      '{CH_COMMA, 1'b0, NO_ITEM},
      '{8'h80,    1'b0, NO_ITEM},
      '{8'h7F,    1'b0, NO_ITEM},
      '{CH_LF,    1'b1, BARE_B},
      '{8'h00,    1'b0, NO_ITEM},
      '{8'h1F,    1'b0, NO_ITEM},
      '{CH_LF,    1'b1, BARE_B}
   };

   serial_command_line_parser_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_rx_byte       (req_rx_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_command_code  (rsp_command_code),
      .rsp_char_value    (rsp_char_value),
      .rsp_first_length  (rsp_first_length),
      .rsp_second_length (rsp_second_length),
      .rsp_last_of_line  (rsp_last_of_line)
   );

   initial begin
      forever begin
         #CLOCK_HALF clock = ~clock;
      end
   end

   function automatic parsed_item_type line_item(input logic [1:0] kind,
                                                 input logic [7:0] ch, input bit last);
      parsed_item_type item;
      item.kind       = kind;
      item.command    = cmd_held;
      item.char_value = ch;
      item.first_len  = 4'(first_n);
      item.second_len = 4'(second_n);
      item.last       = last;
      return item;
   endfunction

   task automatic parse_byte(input logic [7:0] b);
      line_items.delete();
      if (b < PRINT_LO || b > PRINT_HI) begin
         line_mode = MODE_IGNORE;
      end
      if (b == CH_LF) begin
         line_mode = MODE_COMMAND;
         line_items.push_back(line_item(KIND_HEADER, 8'h00, first_n == 0 && second_n == 0));
         for (int i = 0; i < first_n; i++) begin
            line_items.push_back(line_item(KIND_FIRST, first_chars[i],
                                           i + 1 == first_n && second_n == 0));
         end
         for (int i = 0; i < second_n; i++) begin
            line_items.push_back(line_item(KIND_SECOND, second_chars[i], i + 1 == second_n));
         end
      end else if (b != CH_CR) begin
         case (line_mode)
            MODE_COMMAND: begin
               if (b == CH_COMMA) begin
                  line_mode = MODE_FIRST;
               end else begin
                  cmd_held = b;
                  first_n  = 0;
                  second_n = 0;
               end
            end
            MODE_FIRST: begin
               if (b == CH_COMMA) begin
                  line_mode = MODE_SECOND;
               end else if (first_n < ARG_CAP) begin
                  first_chars[first_n] = b;
                  first_n++;
               end
            end
            MODE_SECOND: begin
               if (b == CH_COMMA) begin
                  line_mode = MODE_IGNORE;
               end else if (second_n < ARG_CAP) begin
                  second_chars[second_n] = b;
                  second_n++;
               end
            end
            default: begin
            end
         endcase
      end
   endtask

   // hold the byte until the transfer, then queue what the line parser emits
   task automatic send_byte(input logic [7:0] value, input bit fixed = 1'b0,
                            input parsed_item_type fixed_item = '0);
      req_push    <= 1'b1;
      req_rx_byte <= value;
      do begin
         @(posedge clock);
      end while (req_full);
      bytes_sent++;
      parse_byte(value);
      if (fixed) begin
         items_due.push_back(fixed_item);
      end else begin
         foreach (line_items[i]) items_due.push_back(line_items[i]);
      end
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      c = 8'($urandom_range(32, 125));
      if (c >= CH_COMMA) c = c + 8'd1;
      return c;
   endfunction

   task automatic send_random_line();
      int pick;
      int fields;
      int len;
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
         if ($urandom_range(0, 7) != 0) send_byte(text_char());
         fields = $urandom_range(0, 2);
         for (int f = 0; f < fields; f++) begin
            send_byte(CH_COMMA);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 6);
            repeat (len) send_byte(text_char());
         end
      end else if (pick == 8) begin
         send_byte(text_char());
         repeat ($urandom_range(2, 8)) begin
            case ($urandom_range(0, 3))
               0: send_byte(CH_COMMA);
               1: send_byte(8'($urandom_range(0, 255)));
               default: send_byte(text_char());
            endcase
         end
      end else if (pick == 9) begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[r]) begin
         send_byte(directed_rows[r].rx, directed_rows[r].fixed, directed_rows[r].item);
      end
      // drain everything before the random part
      req_push <= 1'b0;
      @(posedge clock);
      while (items_due.size() != 0) @(posedge clock);
      while (bytes_sent < ITEM_TARGET) begin
         if (bytes_sent >= CALM_AFTER) calm = 1'b1;
         send_random_line();
      end
      req_push <= 1'b0;
      while (items_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 11) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_items
      parsed_item_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (items_due.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual kind %0h char %0h",
                     $time, rsp_item_kind, rsp_char_value);
            mismatch_count++;
         end else begin
            want = items_due.pop_front();
            compare_field("item_kind", 8'(want.kind), 8'(rsp_item_kind));
            compare_field("command_code", want.command, rsp_command_code);
            compare_field("char_value", want.char_value, rsp_char_value);
            compare_field("first_length", 8'(want.first_len), 8'(rsp_first_length));
            compare_field("second_length", 8'(want.second_len), 8'(rsp_second_length));
            compare_field("last_of_line", 8'(want.last), 8'(rsp_last_of_line));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
